/* rtl/text_console_writer_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the text console writer
// Shared helpers for the concurrent checks on the block's ports.
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_WRITER_MACROS_SVH
`define TEXT_CONSOLE_WRITER_MACROS_SVH

// General check: the property holds at every rising edge out of reset.
`define TCW_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("text console writer check failed");

// Handshake check: a stalled beat keeps valid high and its payload unchanged.
`define TCW_ASSERT_HOLD(lbl, clk, rst_n, vld, rdy, pay) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) \
    ((vld) && !(rdy)) |=> ((vld) && $stable(pay))) \
    else $error("text console writer stalled beat changed");

`endif

/* rtl/tcw_pkg.sv */
// ----------------------------------------------------------------------------
// tcw_pkg
// Types and constants shared by the text console writer modules.
// ----------------------------------------------------------------------------
package tcw_pkg;

  // Screen geometry.
  localparam int unsigned COLUMNS     = 80;
  localparam int unsigned ROWS        = 25;
  localparam int unsigned CELLS       = COLUMNS * ROWS;
  localparam int unsigned SCROLL_BASE = (ROWS - 1) * COLUMNS;
  localparam int unsigned COPY_CELLS  = (ROWS - 2) * COLUMNS;

  // Field widths.
  localparam int unsigned CMD_W  = 2;
  localparam int unsigned CODE_W = 9;
  localparam int unsigned POS_W  = 11;
  localparam int unsigned CELL_W = 16;
  localparam int unsigned ATTR_W = 8;
  localparam int unsigned ADDR_W = $clog2(CELLS);

  // Character codes and reset attribute.
  localparam logic [CODE_W-1:0] CODE_NEWLINE   = 9'd10;
  localparam logic [CODE_W-1:0] CODE_BACKSPACE = 9'd256;
  localparam logic [7:0]        BLANK_CHAR     = 8'h20;
  localparam logic [ATTR_W-1:0] ATTR_RESET     = 8'h07;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUT        = 2'd0,
    CMD_SET_CURSOR = 2'd1,
    CMD_READ       = 2'd2,
    CMD_NONE       = 2'd3
  } tcw_cmd_e;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [CODE_W-1:0] char_code;
    logic [POS_W-1:0]  position;
  } tcw_in_t;

  typedef struct packed {
    logic [POS_W-1:0]  cursor_position;
    logic [CELL_W-1:0] cell_data;
    logic              error;
  } tcw_out_t;

  // Access request from the sequencer to the cell memory.
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [CELL_W-1:0] wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } tcw_mem_req_t;

endpackage

/* rtl/text_console_writer.sv */
// ----------------------------------------------------------------------------
// text_console_writer
// Text-mode console engine with an 80x25 store of attribute/character cells.
// ----------------------------------------------------------------------------
// Input beats on in_valid_i/in_ready_o carry a command: put character,
// set cursor, or read cell. Every input beat yields exactly one result beat
// on out_valid_o/out_ready_i with the cursor, the cell read (zero otherwise)
// and an error flag for refused steps. The attribute byte is written through
// cfg_valid_i/cfg_data_i, which is always ready; write it only while idle.
// Items are handled one at a time. A read runs S_CALC, S_RDWAIT, S_DONE;
// a set cursor S_CALC, S_DONE; a put without scroll S_CALC, S_BLANK, S_DONE.
// A put that reaches the last row scrolls: the single-write-port cell RAM
// copies 1840 cells at one per cycle and clears up to a row. After reset
// the block sweeps zeros through all 2000 cells, one per cycle, and holds
// in_ready_o low until the sweep ends; the attribute resets to 7.
// The result register frees the engine: a new item is accepted while a
// result waits, and a stalled receiver only holds the next result back.
// ----------------------------------------------------------------------------
module text_console_writer
  import tcw_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [ATTR_W-1:0] cfg_data_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  tcw_in_t           in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output tcw_out_t          out_data_o
);

  logic [ATTR_W-1:0] attr_q, attr_d;
  tcw_mem_req_t      mem_req;
  logic [CELL_W-1:0] mem_rdata;

  // Attribute register.
  assign cfg_ready_o = 1'b1;
  assign attr_d      = cfg_valid_i ? cfg_data_i : attr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attr_q <= ATTR_RESET;
    end else begin
      attr_q <= attr_d;
    end
  end

  tcw_sequencer u_sequencer (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .attr_i      (attr_q),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .mem_req_o   (mem_req),
    .mem_rdata_i (mem_rdata)
  );

  tcw_cell_ram #(
    .DEPTH (CELLS),
    .WIDTH (CELL_W)
  ) u_cell_ram (
    .clk_i   (clk_i),
    .we_i    (mem_req.we),
    .waddr_i (mem_req.waddr),
    .wdata_i (mem_req.wdata),
    .re_i    (mem_req.re),
    .raddr_i (mem_req.raddr),
    .rdata_o (mem_rdata)
  );

endmodule

/* rtl/tcw_cell_ram.sv */
// ----------------------------------------------------------------------------
// tcw_cell_ram
// Simple dual-port synchronous RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module tcw_cell_ram #(
  parameter int unsigned DEPTH = 2000,
  parameter int unsigned WIDTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port, and read port with a registered output.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/tcw_sequencer.sv */
// ----------------------------------------------------------------------------
// tcw_sequencer
// Command decode, cursor update and the memory sweeps for clear and scroll.
// ----------------------------------------------------------------------------
module tcw_sequencer
  import tcw_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [ATTR_W-1:0] attr_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  tcw_in_t           in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output tcw_out_t          out_data_o,
  output tcw_mem_req_t      mem_req_o,
  input  logic [CELL_W-1:0] mem_rdata_i
);

  localparam int unsigned CNT_W = ADDR_W + 1;
  localparam int unsigned ROW_W = $clog2(ROWS + 1);
  localparam int unsigned NPOS_W = POS_W + 1;

  // Reciprocal of the row length, rounded up; exact for every cursor value.
  localparam int unsigned RECIP_SH = POS_W + 8;
  localparam int unsigned RECIP    = ((1 << RECIP_SH) + COLUMNS - 1) / COLUMNS;
  localparam int unsigned RECIP_W  = $clog2(RECIP + 1);
  localparam int unsigned PROD_W   = POS_W + RECIP_W;

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_CALC   = 3'd2;
  localparam logic [2:0] S_RDWAIT = 3'd3;
  localparam logic [2:0] S_COPY   = 3'd4;
  localparam logic [2:0] S_ZERO   = 3'd5;
  localparam logic [2:0] S_BLANK  = 3'd6;
  localparam logic [2:0] S_DONE   = 3'd7;

  logic [2:0]        state_q, state_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [POS_W-1:0]  cursor_q, cursor_d;
  logic              out_valid_q, out_valid_d;
  tcw_out_t          out_q, out_d;
  tcw_in_t           item_q, item_d;
  logic [ROW_W-1:0]  row_q, row_d;
  logic              err_q, err_d;
  logic [CELL_W-1:0] data_q, data_d;

  logic [PROD_W-1:0] row_prod;
  logic [NPOS_W-1:0] nl_pos, put_pos, put_fin;
  logic              printable, scroll, out_free;

  // Row of the current cursor, registered at acceptance.
  assign row_prod = PROD_W'(cursor_q) * PROD_W'(RECIP);
  assign row_d    = ROW_W'(row_prod >> RECIP_SH);

  // New cursor of a put-character beat, from the registered row.
  assign nl_pos    = (NPOS_W'(row_q) + 1'b1) * NPOS_W'(COLUMNS);
  assign printable = (item_q.char_code != CODE_NEWLINE) &&
                     (item_q.char_code != CODE_BACKSPACE);

  always_comb begin
    if (item_q.char_code == CODE_NEWLINE) begin
      put_pos = nl_pos;
    end else if (item_q.char_code == CODE_BACKSPACE) begin
      put_pos = (cursor_q == '0) ? '0 : NPOS_W'(cursor_q) - 1'b1;
    end else begin
      put_pos = NPOS_W'(cursor_q) + 1'b1;
    end
  end

  assign scroll  = put_pos >= NPOS_W'(SCROLL_BASE);
  assign put_fin = scroll ? put_pos - NPOS_W'(COLUMNS) : put_pos;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE);

  // Next-state and memory request logic.
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    cursor_d    = cursor_q;
    item_d      = item_q;
    err_d       = err_q;
    data_d      = data_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    mem_req_o   = '0;

    unique case (state_q)
      S_CLEAR: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = cnt_q[ADDR_W-1:0];
        mem_req_o.wdata = '0;
        if (cnt_q == CNT_W'(CELLS - 1)) begin
          state_d = S_IDLE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          item_d  = in_data_i;
          err_d   = 1'b0;
          data_d  = '0;
          state_d = S_CALC;
        end
      end
      S_CALC: begin
        unique case (tcw_cmd_e'(item_q.command))
          CMD_PUT: begin
            if (put_pos > NPOS_W'(CELLS)) begin
              err_d   = 1'b1;
              state_d = S_DONE;
            end else begin
              if (printable) begin
                mem_req_o.we    = 1'b1;
                mem_req_o.waddr = cursor_q[ADDR_W-1:0];
                mem_req_o.wdata = {attr_i, item_q.char_code[7:0]};
              end
              cursor_d = POS_W'(put_fin);
              cnt_d    = '0;
              state_d  = scroll ? S_COPY : S_BLANK;
            end
          end
          CMD_SET_CURSOR: begin
            if (item_q.position > POS_W'(CELLS)) begin
              err_d = 1'b1;
            end else begin
              cursor_d = item_q.position;
            end
            state_d = S_DONE;
          end
          CMD_READ: begin
            if (item_q.position < POS_W'(CELLS)) begin
              mem_req_o.re    = 1'b1;
              mem_req_o.raddr = item_q.position[ADDR_W-1:0];
              state_d         = S_RDWAIT;
            end else begin
              err_d   = 1'b1;
              state_d = S_DONE;
            end
          end
          CMD_NONE: begin
            state_d = S_DONE;
          end
        endcase
      end
      S_RDWAIT: begin
        data_d  = mem_rdata_i;
        state_d = S_DONE;
      end
      S_COPY: begin
        // Read one row ahead of the write; the write takes last cycle's read.
        if (cnt_q < CNT_W'(COPY_CELLS)) begin
          mem_req_o.re    = 1'b1;
          mem_req_o.raddr = ADDR_W'(cnt_q + CNT_W'(COLUMNS));
        end
        if (cnt_q != '0) begin
          mem_req_o.we    = 1'b1;
          mem_req_o.waddr = ADDR_W'(cnt_q - 1'b1);
          mem_req_o.wdata = mem_rdata_i;
        end
        if (cnt_q == CNT_W'(COPY_CELLS)) begin
          cnt_d   = CNT_W'(cursor_q);
          state_d = S_ZERO;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_ZERO: begin
        if (cnt_q < CNT_W'(SCROLL_BASE)) begin
          mem_req_o.we    = 1'b1;
          mem_req_o.waddr = cnt_q[ADDR_W-1:0];
          mem_req_o.wdata = '0;
          cnt_d           = cnt_q + 1'b1;
        end else begin
          state_d = S_BLANK;
        end
      end
      S_BLANK: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = cursor_q[ADDR_W-1:0];
        mem_req_o.wdata = {attr_i, BLANK_CHAR};
        state_d         = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          out_d.cursor_position = cursor_q;
          out_d.cell_data       = data_q;
          out_d.error           = err_q;
          out_valid_d           = 1'b1;
          state_d               = S_IDLE;
        end
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      cnt_q       <= '0;
      cursor_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      cursor_q    <= cursor_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    err_q  <= err_d;
    data_q <= data_d;
    out_q  <= out_d;
    if (state_q == S_IDLE) begin
      row_q <= row_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

/* rtl/tcw_checker.sv */
// ----------------------------------------------------------------------------
// tcw_checker
// Port-level checks on the text console writer, bound to the top level.
// ----------------------------------------------------------------------------
`include "text_console_writer_macros.svh"

module tcw_checker
  import tcw_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              cfg_valid_i,
  input logic              cfg_ready_o,
  input logic [ATTR_W-1:0] cfg_data_i,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input tcw_in_t           in_data_i,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input tcw_out_t          out_data_o
);

  logic unused_inputs;
  assign unused_inputs = cfg_valid_i ^ cfg_ready_o ^ (^cfg_data_i) ^ (^in_data_i);

  // A stalled result beat holds.
  `TCW_ASSERT_HOLD(a_out_hold, clk_i, rst_ni, out_valid_o, out_ready_i, out_data_o)

  // Items are handled one at a time: no acceptance right after another.
  `TCW_ASSERT(a_one_at_a_time, clk_i, rst_ni,
              (in_valid_i && in_ready_o) |=> !in_ready_o)

  // A refused step never carries cell data.
  `TCW_ASSERT(a_error_no_data, clk_i, rst_ni,
              (out_valid_o && out_data_o.error) |-> (out_data_o.cell_data == '0))

  // The reported cursor stays within the store and its end position.
  `TCW_ASSERT(a_cursor_range, clk_i, rst_ni,
              out_valid_o |-> (out_data_o.cursor_position <= POS_W'(CELLS)))

endmodule

bind text_console_writer tcw_checker u_checker (.*);

/* test/tb_text_console_writer.sv */
// ----------------------------------------------------------------------------
// tb_text_console_writer
// Self-checking testbench for the text console writer.
// ----------------------------------------------------------------------------
// A short directed sequence covers reads at both ends of the store and past
// it, every put-character case, the unused command, cursor overflow and the
// scroll at the last row. Random commands follow in several attribute
// phases. Most of them keep the cursor close to the bottom rows, so scrolls
// happen often. A scoreboard predicts one result per accepted command beat.
// It compares each result beat field by field with the oldest prediction.
// Both channels stall at random, except in the last phase.
// ----------------------------------------------------------------------------
module tb_text_console_writer;
  import tcw_pkg::*;

  // Predicts console results and keeps them in order until they arrive.
  class console_scoreboard;
    logic [POS_W-1:0]  cursor;
    logic [CELL_W-1:0] cells [CELLS];
    logic [ATTR_W-1:0] attribute;
    tcw_out_t          expected_results [$];
    int unsigned       errors;

    function new();
      cursor    = '0;
      attribute = ATTR_RESET;
      errors    = 0;
      foreach (cells[i]) cells[i] = '0;
    endfunction

    function void set_attribute(logic [ATTR_W-1:0] value);
      attribute = value;
    endfunction

    // Returns 1 when the put is refused because the cursor would leave range.
    function bit put_character(logic [CODE_W-1:0] code);
      int unsigned pos;
      int unsigned i;
      pos = cursor;
      if (code == CODE_NEWLINE) begin
        pos = pos + COLUMNS - (pos % COLUMNS);
      end else if (code == CODE_BACKSPACE) begin
        if (pos > 0) pos--;
      end else begin
        pos++;
      end
      if (pos > CELLS) return 1'b1;

      if (code != CODE_NEWLINE && code != CODE_BACKSPACE) begin
        cells[cursor] = {attribute, code[7:0]};
      end

      // Reaching the last row moves rows 1 to ROWS-2 up and clears row ROWS-2 from the new cursor on.
      if (pos / COLUMNS >= ROWS - 1) begin
        for (i = 0; i < COPY_CELLS; i++) cells[i] = cells[i + COLUMNS];
        pos -= COLUMNS;
        for (i = pos; i < SCROLL_BASE; i++) cells[i] = '0;
      end

      cursor = POS_W'(pos);
      if (pos < CELLS) cells[pos] = {attribute, BLANK_CHAR};
      return 1'b0;
    endfunction

    function tcw_out_t console_step(tcw_in_t item);
      tcw_out_t    res;
      int unsigned addr;
      res  = '0;
      addr = item.position;
      case (tcw_cmd_e'(item.command))
        CMD_PUT: begin
          res.error = put_character(item.char_code);
        end
        CMD_SET_CURSOR: begin
          if (addr > CELLS) res.error = 1'b1;
          else cursor = POS_W'(addr);
        end
        CMD_READ: begin
          if (addr < CELLS) res.cell_data = cells[addr];
          else res.error = 1'b1;
        end
        default: begin
        end
      endcase
      res.cursor_position = cursor;
      return res;
    endfunction

    function void note_command(tcw_in_t item);
      expected_results.push_back(console_step(item));
    endfunction

    function void report(string field, int unsigned want, int unsigned got);
      errors++;
      // Keep the log short when the design is badly off.
      if (errors <= 200) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      end
    endfunction

    function void check_result(tcw_out_t got);
      tcw_out_t want;
      if (expected_results.size() == 0) begin
        errors++;
        $display("%0t: result beat with nothing pending, expected none, actual %h",
                 $time, got);
        return;
      end
      want = expected_results.pop_front();
      if (got.cursor_position !== want.cursor_position) begin
        report("cursor_position", want.cursor_position, got.cursor_position);
      end
      if (got.cell_data !== want.cell_data) begin
        report("cell_data", want.cell_data, got.cell_data);
      end
      if (got.error !== want.error) begin
        report("error", want.error, got.error);
      end
    endfunction

    function int unsigned pending();
      return expected_results.size();
    endfunction
  endclass

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              cfg_valid_i = 1'b0;
  logic              cfg_ready_o;
  logic [ATTR_W-1:0] cfg_data_i  = '0;
  logic              in_valid_i  = 1'b0;
  logic              in_ready_o;
  tcw_in_t           in_data_i   = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  tcw_out_t          out_data_o;

  console_scoreboard sb;
  bit                idle_on = 1'b1;

  text_console_writer DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  // Clock generation.
  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // Overall time limit.
  initial begin
    #80_000_000;
    $display("status: fail");
    $finish;
  end

  function automatic tcw_in_t make_cmd(tcw_cmd_e cmd, int unsigned code, int unsigned pos);
    tcw_in_t item;
    item.command   = cmd;
    item.char_code = code[CODE_W-1:0];
    item.position  = pos[POS_W-1:0];
    return item;
  endfunction

  // Random command; most of them keep the cursor near the bottom rows.
  function automatic tcw_in_t random_cmd();
    tcw_in_t     item;
    int unsigned sel;
    int unsigned sub;
    item.char_code = CODE_W'($urandom_range(0, 511));
    item.position  = POS_W'($urandom_range(0, 2047));
    sel = $urandom_range(0, 99);
    sub = $urandom_range(0, 9);
    if (sel < 50) begin
      item.command = CMD_PUT;
      if (sub < 2) item.char_code = CODE_NEWLINE;
      else if (sub == 2) item.char_code = CODE_BACKSPACE;
      else if (sub == 3) item.char_code = CODE_W'($urandom_range(257, 511));
      else item.char_code = CODE_W'($urandom_range(0, 255));
    end else if (sel < 65) begin
      item.command = CMD_SET_CURSOR;
      if (sub < 7) item.position = POS_W'($urandom_range(SCROLL_BASE - COLUMNS, CELLS));
      else if (sub < 9) item.position = POS_W'($urandom_range(0, CELLS));
      else item.position = POS_W'($urandom_range(CELLS + 1, 2047));
    end else if (sel < 93) begin
      item.command = CMD_READ;
      if (sub < 6) item.position = POS_W'($urandom_range(SCROLL_BASE - 2 * COLUMNS, 2047));
    end else begin
      item.command = CMD_NONE;
    end
    return item;
  endfunction

  // Drives one command beat and notes it at acceptance.
  task automatic send_command(input tcw_in_t item);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_command(item);
  endtask

  // Stops sending and waits until every predicted result has arrived.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  task automatic write_attribute(input logic [ATTR_W-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    sb.set_attribute(value);
  endtask

  task automatic run_random(input int unsigned count);
    repeat (count) send_command(random_cmd());
  endtask

  // Result receiver with random stall bursts.
  initial begin
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (idle_on && $urandom_range(0, 2) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      repeat ($urandom_range(1, 20)) @(posedge clk_i);
    end
  end

  // Result monitor.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_result(out_data_o);
  end

  // Main sequence.
  initial begin
    sb = new();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part with the reset attribute: reads and simple puts.
    send_command(make_cmd(CMD_READ, 0, 0));
    send_command(make_cmd(CMD_READ, 511, CELLS - 1));
    send_command(make_cmd(CMD_READ, 0, 2047));
    send_command(make_cmd(CMD_READ, 0, CELLS));
    send_command(make_cmd(CMD_PUT, 72, 2047));
    send_command(make_cmd(CMD_PUT, 0, 0));
    send_command(make_cmd(CMD_PUT, 255, 0));
    send_command(make_cmd(CMD_READ, 0, 0));
    send_command(make_cmd(CMD_PUT, CODE_BACKSPACE, 0));
    send_command(make_cmd(CMD_PUT, CODE_NEWLINE, 0));
    send_command(make_cmd(CMD_SET_CURSOR, 0, 0));
    // Backspace at the first cell stays there.
    send_command(make_cmd(CMD_PUT, CODE_BACKSPACE, 0));
    send_command(make_cmd(CMD_NONE, 511, 2047));

    drain_results();
    write_attribute(8'hFF);

    // Cursor limits, refused puts and the scroll cases.
    send_command(make_cmd(CMD_SET_CURSOR, 0, CELLS + 1));
    send_command(make_cmd(CMD_SET_CURSOR, 0, 2047));
    send_command(make_cmd(CMD_SET_CURSOR, 0, CELLS));
    send_command(make_cmd(CMD_PUT, 120, 0));
    send_command(make_cmd(CMD_PUT, CODE_NEWLINE, 0));
    send_command(make_cmd(CMD_PUT, CODE_BACKSPACE, 0));
    send_command(make_cmd(CMD_SET_CURSOR, 0, SCROLL_BASE - 1));
    send_command(make_cmd(CMD_PUT, 266, 0));
    send_command(make_cmd(CMD_SET_CURSOR, 0, CELLS - 1));
    send_command(make_cmd(CMD_PUT, 122, 0));
    send_command(make_cmd(CMD_SET_CURSOR, 0, SCROLL_BASE - 20));
    send_command(make_cmd(CMD_PUT, CODE_NEWLINE, 0));
    send_command(make_cmd(CMD_READ, 0, SCROLL_BASE - 1));
    send_command(make_cmd(CMD_READ, 0, SCROLL_BASE));

    // Random phases under different attributes; the last one runs unstalled.
    drain_results();
    write_attribute(8'h00);
    run_random(66);
    drain_results();
    write_attribute(ATTR_W'($urandom_range(1, 254)));
    run_random(66);
    drain_results();
    write_attribute(8'hFF);
    run_random(66);
    drain_results();
    write_attribute(ATTR_W'($urandom_range(0, 255)));
    idle_on = 1'b0;
    run_random(66);

    drain_results();
    repeat (2100) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
